### rtl/pfb_pkg.sv
// Package for the page framebuffer text blitter: constants, action codes,
// payload structs, controller state type and the command/status structs.
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int DisplayWidthDefault = 128;
  localparam int DisplayPagesDefault = 8;
  localparam int StoreDepth          = 1024;
  localparam int AddrW               = 10;

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharReturn  = 8'd13;

  typedef enum logic [2:0] {
    ACT_SET_CURSOR = 3'd0,
    ACT_CHAR       = 3'd1,
    ACT_CHAR_2X    = 3'd2,
    ACT_PIXEL      = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_CLEAR_LINE = 3'd5,
    ACT_READ       = 3'd6,
    ACT_NONE       = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  char_code;
    logic [63:0] glyph_columns;
    logic [7:0]  x_position;
    logic [7:0]  y_position;
    logic        pixel_color;
    logic [7:0]  page_index;
    logic [9:0]  read_address;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
    logic [7:0] cursor_x_now;
    logic [7:0] cursor_y_now;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_SWEEP,     // clearing pass over the whole store
    ST_IDLE,
    ST_DECODE,    // cursor update / wrap, choose work
    ST_DISPATCH,  // branch on the decoded kind of work
    ST_RD,        // issue memory read of one target byte
    ST_WAIT,      // read data registered
    ST_WR,        // write modified byte
    ST_LINE,      // zero one page, one byte a cycle
    ST_RDONE,     // read action data wait
    ST_OUT        // result held until taken
  } state_t;

  // Datapath operations the controller requests.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture the input transaction
    OP_DECODE,    // apply cursor rules, set up counters
    OP_RD,        // read address of current target
    OP_WR,        // write modified byte, advance target
    OP_LINE,      // write zero, advance column
    OP_SWEEP,     // write zero, advance sweep address
    OP_RDCAP,     // capture read data
    OP_SEND       // load output register
  } op_t;

  typedef struct packed {
    op_t op;
  } pfb_cmd_t;

  typedef struct packed {
    logic draw;      // decoded item needs glyph/pixel RMW
    logic line;      // decoded item clears a page
    logic sweep;     // decoded item clears the store
    logic rd;        // decoded item is a read
    logic last;      // current counter is at its final step
    logic out_taken; // output register is free
  } pfb_stat_t;

  function automatic logic [15:0] double_bits(input logic [7:0] b);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i]   = b[i];
      r[2*i+1] = b[i];
    end
    return r;
  endfunction

endpackage

### rtl/page_framebuffer_text_blitter.sv
// Top level of the page framebuffer text blitter: controller plus datapath.
// Depends on pfb_pkg, pfb_ctrl and pfb_datapath.
//
// Usage: an input transaction on in_valid/in_stall carries one action (set
// cursor, draw char 8x8 or 16x16, pixel, clear, clear line, read). Each
// accepted transaction produces exactly one output transaction on
// out_valid/out_stall holding status, read data and the cursor afterward.
// One item is worked at a time; the framebuffer memory, with one write port
// and one read port, sets the cost. A glyph is read, modified and written
// back byte by byte over its targets (24 byte targets for 8x8, 48 for
// 16x16). in_stall drops again the cycle after the result is taken.
// After reset the block first runs a clearing pass over all 1024 bytes of
// the framebuffer, and in_stall stays high all through it; no result is
// sent for that pass. When the receiver stalls, the result stays in the
// output register and no new item is taken until it leaves.
`timescale 1ns / 1ps

module page_framebuffer_text_blitter #(
  parameter int DISPLAY_WIDTH = pfb_pkg::DisplayWidthDefault,
  parameter int DISPLAY_PAGES = pfb_pkg::DisplayPagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfb_pkg::out_item_t out_data
);
  import pfb_pkg::*;

  pfb_cmd_t  cmd;
  pfb_stat_t stat;
  pfb_cmd_t  cmd_gated;
  logic      boot;

  // The reset sweep ends without a result: boot marks that first pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot <= 1'b1;
    end else if (cmd.op == OP_SEND) begin
      boot <= 1'b0;
    end
  end

  always_comb begin
    cmd_gated = cmd;
    if (boot && cmd.op == OP_SEND) cmd_gated.op = OP_NONE;
  end

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfb_datapath #(
    .DisplayWidth (DISPLAY_WIDTH),
    .DisplayPages (DISPLAY_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_data),
    .cmd       (cmd_gated),
    .stat      (stat),
    .out_item  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

`ifndef ASSERT_OFF
  // No new item is taken while a result waits.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item accepted while result pending");
  // An accepted item is followed by a busy block.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("ready after accept");
  // The result appears only from the send command.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd_gated.op == OP_SEND))
    else $error("unexpected result");
`endif

endmodule

### rtl/pfb_ctrl.sv
// Controller state machine of the page framebuffer text blitter.
// Depends on pfb_pkg for state, command and status types.
`timescale 1ns / 1ps

module pfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfb_pkg::pfb_stat_t stat,
  output pfb_pkg::pfb_cmd_t  cmd
);
  import pfb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    case (state)
      ST_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (stat.last) state_next = ST_OUT;
      end
      ST_IDLE: begin
        // A result still waiting in the output register keeps the input closed.
        in_stall = !stat.out_taken;
        if (in_valid && stat.out_taken) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.op     = OP_DECODE;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat.sweep) state_next = ST_SWEEP;
        else if (stat.line) state_next = ST_LINE;
        else if (stat.draw) state_next = ST_RD;
        else if (stat.rd) state_next = ST_RDONE;
        else state_next = ST_OUT;
      end
      ST_RD: begin
        cmd.op     = OP_RD;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.op     = OP_WR;
        state_next = stat.last ? ST_OUT : ST_RD;
      end
      ST_LINE: begin
        cmd.op = OP_LINE;
        if (stat.last) state_next = ST_OUT;
      end
      ST_RDONE: begin
        cmd.op     = OP_RDCAP;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_taken) begin
          cmd.op     = OP_SEND;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/pfb_datapath.sv
// Datapath of the page framebuffer text blitter: item register, cursor,
// framebuffer memory, glyph target counters and output register. Uses pfb_pkg.
`timescale 1ns / 1ps

module pfb_datapath #(
  parameter int DisplayWidth = pfb_pkg::DisplayWidthDefault,
  parameter int DisplayPages = pfb_pkg::DisplayPagesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  pfb_pkg::in_item_t   in_item,
  input  pfb_pkg::pfb_cmd_t   cmd,
  output pfb_pkg::pfb_stat_t  stat,
  output pfb_pkg::out_item_t  out_item,
  output logic                out_valid,
  input  logic                out_stall
);
  import pfb_pkg::*;

  localparam int DisplayRows = DisplayPages * 8;
  localparam int ColW        = $clog2(DisplayWidth);

  logic [7:0]  mem [StoreDepth];
  logic [7:0]  rdata;
  logic [AddrW-1:0] raddr;

  in_item_t    item;
  logic [7:0]  cx, cy;
  logic        status;
  logic [7:0]  data;
  logic        twice;
  logic [2:0]  off;
  logic [4:0]  page_base;
  logic [4:0]  col;     // output column within glyph, 0..15
  logic [1:0]  seg;     // page segment 0..2
  logic [7:0]  x0;      // glyph left edge
  logic [AddrW:0] sweep_cnt;
  logic [ColW-1:0] line_col;
  logic        draw_pixel;
  logic        kind_draw, kind_line, kind_sweep, kind_rd;

  // Target of the current RMW step.
  logic [2:0]  gcol;
  logic [7:0]  gbyte;
  logic [15:0] tall;
  logic [23:0] shifted;
  logic [7:0]  bits;
  logic [8:0]  tx;
  logic [5:0]  tpage;
  logic        tvalid;
  logic [AddrW-1:0] taddr;
  logic [7:0]  wbyte;
  logic        last_step;
  logic [4:0]  cols_total;
  logic [7:0]  size;
  logic [8:0]  x_sum;

  always_comb begin
    gcol    = twice ? col[3:1] : col[2:0];
    gbyte   = item.glyph_columns[8*gcol +: 8];
    tall    = twice ? double_bits(gbyte) : {8'h00, gbyte};
    shifted = {8'h00, tall} << off;
    case (seg)
      2'd0:    bits = shifted[7:0];
      2'd1:    bits = shifted[15:8];
      default: bits = shifted[23:16];
    endcase
    tx     = {1'b0, x0} + {4'd0, col};
    tpage  = {1'b0, page_base} + {4'd0, seg};
    tvalid = (tx < 9'(DisplayWidth)) && (tpage < 6'(DisplayPages));
    taddr  = draw_pixel ? AddrW'({2'b00, item.y_position[7:3]} * DisplayWidth
                                 + item.x_position)
                        : AddrW'(tpage * DisplayWidth + tx);
    if (draw_pixel) begin
      wbyte = item.pixel_color ? (rdata | (8'd1 << item.y_position[2:0]))
                               : (rdata & ~(8'd1 << item.y_position[2:0]));
    end else begin
      wbyte = rdata | (tvalid ? bits : 8'h00);
    end
    cols_total = twice ? 5'd15 : 5'd7;
    last_step  = draw_pixel || (col == cols_total && seg == 2'd2);
    size       = twice ? 8'd16 : 8'd8;
    x_sum      = {1'b0, cx} + {1'b0, size};
  end

  always_comb begin
    stat.draw      = kind_draw;
    stat.line      = kind_line;
    stat.sweep     = kind_sweep;
    stat.rd        = kind_rd;
    stat.out_taken = !out_valid;
    case (cmd.op)
      OP_SWEEP: stat.last = (sweep_cnt == (AddrW+1)'(StoreDepth - 1));
      OP_LINE:  stat.last = (line_col == ColW'(DisplayWidth - 1));
      default:  stat.last = last_step;
    endcase
  end

  // Memory: one write port, one registered read port.
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;
  always_comb begin
    we    = 1'b0;
    waddr = taddr;
    wdata = wbyte;
    // A read action keeps its address on the port until the data is captured.
    raddr = (action_t'(item.action) == ACT_READ) ? item.read_address : taddr;
    case (cmd.op)
      OP_WR: we = 1'b1;
      OP_SWEEP: begin
        we = 1'b1; waddr = sweep_cnt[AddrW-1:0]; wdata = 8'h00;
      end
      OP_LINE: begin
        we = 1'b1;
        waddr = AddrW'(item.page_index[2:0] * DisplayWidth + line_col);
        wdata = 8'h00;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0; cy <= '0; out_valid <= 1'b0; sweep_cnt <= '0;
      kind_draw <= 1'b0; kind_line <= 1'b0; kind_sweep <= 1'b0; kind_rd <= 1'b0;
      status <= 1'b0; data <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          item <= in_item;
          status <= 1'b0; data <= '0;
          twice <= (in_item.action == ACT_CHAR_2X);
          kind_draw <= 1'b0; kind_line <= 1'b0; kind_sweep <= 1'b0; kind_rd <= 1'b0;
          sweep_cnt <= '0; line_col <= '0; col <= '0; seg <= '0;
          draw_pixel <= 1'b0;
        end
        OP_DECODE: begin
          case (action_t'(item.action))
            ACT_SET_CURSOR: begin
              cx <= item.x_position; cy <= item.y_position;
            end
            ACT_CHAR, ACT_CHAR_2X: begin
              if (item.char_code == CharNewline) begin
                cx <= '0; cy <= cy + size;
              end else if (item.char_code == CharReturn) begin
                cx <= '0;
              end else begin
                logic [7:0] nx, ny;
                logic [8:0] y_sum;
                nx = cx; ny = cy;
                if (x_sum > 9'(DisplayWidth)) begin
                  nx = '0; ny = cy + size;
                end
                y_sum = {1'b0, ny} + {1'b0, size};
                if (y_sum > 9'(DisplayRows)) ny = '0;
                x0 <= nx;
                off <= ny[2:0];
                page_base <= ny[7:3];
                cx <= nx + size;
                cy <= ny;
                kind_draw <= 1'b1;
              end
            end
            ACT_PIXEL: begin
              if (item.x_position >= 8'(DisplayWidth) ||
                  {1'b0, item.y_position} >= 9'(DisplayRows)) begin
                status <= 1'b1;
              end else begin
                draw_pixel <= 1'b1; kind_draw <= 1'b1;
              end
            end
            ACT_CLEAR: begin
              kind_sweep <= 1'b1; cx <= '0; cy <= '0;
            end
            ACT_CLEAR_LINE: begin
              if (item.page_index >= 8'(DisplayPages)) status <= 1'b1;
              else kind_line <= 1'b1;
            end
            ACT_READ: kind_rd <= 1'b1;
            default: ;
          endcase
        end
        OP_WR: begin
          if (seg == 2'd2) begin
            seg <= '0; col <= col + 5'd1;
          end else begin
            seg <= seg + 2'd1;
          end
        end
        OP_SWEEP: sweep_cnt <= sweep_cnt + 1'b1;
        OP_LINE:  line_col <= line_col + 1'b1;
        OP_RDCAP: data <= rdata;
        OP_SEND: begin
          out_valid <= 1'b1;
          out_item.status       <= status;
          out_item.read_data    <= data;
          out_item.cursor_x_now <= cx;
          out_item.cursor_y_now <= cy;
        end
        default: ;
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the page framebuffer text blitter.
// Depends on pfb_pkg and page_framebuffer_text_blitter; predicts each result
// with an in-bench model of the framebuffer and cursor, and checks in order.
`timescale 1ns / 1ps

module tb_top;
  import pfb_pkg::*;

  localparam int Width = 128;
  localparam int Pages = 8;
  localparam int Rows  = Pages * 8;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  page_framebuffer_text_blitter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Predictor state: a private copy of the framebuffer and the text cursor.
  logic [7:0] pixel_bytes [StoreDepth];
  logic [7:0] cur_x, cur_y;
  out_item_t  expected_results [$];
  int         errors = 0;
  bit         long_hold = 1'b0;
  bit         recv_quiet = 1'b0;

  // OR one byte into the display area; anything beyond the edge is clipped.
  function automatic void merge_byte(int page, int col, logic [7:0] bits);
    if (page < Pages && col < Width) pixel_bytes[page * Width + col] |= bits;
  endfunction

  function automatic void render_glyph(logic [63:0] glyph, bit twice);
    int sz, page, off, x;
    logic [7:0]  colbyte;
    logic [15:0] tall;
    logic [23:0] shifted;
    sz = twice ? 16 : 8;
    // Line wrap first, then the wrap back to the top of the display.
    if (int'(cur_x) + sz > Width) begin
      cur_x = 8'd0;
      cur_y = cur_y + 8'(sz);
    end
    if (int'(cur_y) + sz > Rows) cur_y = 8'd0;
    page = cur_y >> 3;
    off  = cur_y & 7;
    for (int c = 0; c < 8; c++) begin
      colbyte = glyph[8*c +: 8];
      if (twice) begin
        for (int i = 0; i < 8; i++) tall[2*i +: 2] = {2{colbyte[i]}};
      end else begin
        tall = {8'd0, colbyte};
      end
      shifted = {8'd0, tall} << off;
      for (int r = 0; r < (twice ? 2 : 1); r++) begin
        x = int'(cur_x) + c * (twice ? 2 : 1) + r;
        if (x < Width) begin
          merge_byte(page, x, shifted[7:0]);
          merge_byte(page + 1, x, shifted[15:8]);
          merge_byte(page + 2, x, shifted[23:16]);
        end
      end
    end
    cur_x = cur_x + 8'(sz);
  endfunction

  // Work out the one result an accepted transaction causes.
  function automatic out_item_t predict_action(in_item_t it);
    out_item_t r;
    bit twice;
    r = '0;
    case (action_t'(it.action))
      ACT_SET_CURSOR: begin
        cur_x = it.x_position;
        cur_y = it.y_position;
      end
      ACT_CHAR, ACT_CHAR_2X: begin
        twice = (action_t'(it.action) == ACT_CHAR_2X);
        if (it.char_code == CharNewline) begin
          cur_x = 8'd0;
          cur_y = cur_y + (twice ? 8'd16 : 8'd8);
        end else if (it.char_code == CharReturn) begin
          cur_x = 8'd0;
        end else begin
          render_glyph(it.glyph_columns, twice);
        end
      end
      ACT_PIXEL: begin
        if (it.x_position >= Width || it.y_position >= Rows) begin
          r.status = 1'b1;
        end else begin
          pixel_bytes[(it.y_position >> 3) * Width + it.x_position][it.y_position[2:0]] =
            it.pixel_color;
        end
      end
      ACT_CLEAR: begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = 8'd0;
        cur_x = 8'd0;
        cur_y = 8'd0;
      end
      ACT_CLEAR_LINE: begin
        if (it.page_index >= Pages) r.status = 1'b1;
        else for (int c = 0; c < Width; c++) pixel_bytes[it.page_index * Width + c] = 8'd0;
      end
      ACT_READ: r.read_data = pixel_bytes[it.read_address];
      default: ;
    endcase
    r.cursor_x_now = cur_x;
    r.cursor_y_now = cur_y;
    return r;
  endfunction

  // Offer one transaction after a random gap; the prediction is made when it
  // is accepted, so the store of expectations stays in order. Valid stays up
  // after acceptance and is dropped only when a gap follows.
  task automatic send_action(in_item_t it, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_action(it));
  endtask

  function automatic in_item_t blank_item(action_t a);
    in_item_t it;
    it = '0;
    it.action = a;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.action        = 3'($urandom_range(0, 7));
    it.char_code     = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? CharNewline
                       : CharReturn) : 8'($urandom);
    it.glyph_columns = {$urandom, $urandom};
    it.x_position    = $urandom_range(0, 1) ? 8'($urandom_range(0, Width + 8))
                       : 8'($urandom);
    it.y_position    = $urandom_range(0, 1) ? 8'($urandom_range(0, Rows + 8))
                       : 8'($urandom);
    it.pixel_color   = 1'($urandom);
    it.page_index    = $urandom_range(0, 1) ? 8'($urandom_range(0, Pages))
                       : 8'($urandom);
    it.read_address  = 10'($urandom);
    return it;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Extremes of every field, each action, and the special cases: newline and
  // carriage return in both sizes, line wrap, wrap to the top, out-of-range
  // pixel and page, the unused action code, reads at both ends of the store.
  task automatic test_directed();
    in_item_t it;
    it = blank_item(ACT_SET_CURSOR); it.x_position = 8'd124; it.y_position = 8'd60;
    send_action(it);
    it = blank_item(ACT_CHAR); it.char_code = 8'hFF; it.glyph_columns = '1;
    send_action(it);
    it = blank_item(ACT_SET_CURSOR); it.x_position = 8'd3; it.y_position = 8'd5;
    send_action(it);
    it = blank_item(ACT_CHAR_2X); it.char_code = 8'h41;
    it.glyph_columns = 64'h8001_FF00_A55A_0F0F;
    send_action(it);
    it = blank_item(ACT_CHAR); it.char_code = 8'h00; it.glyph_columns = 64'hFFFF_0000_1234_8081;
    send_action(it);
    it = blank_item(ACT_CHAR); it.char_code = CharNewline; send_action(it);
    it = blank_item(ACT_CHAR_2X); it.char_code = CharNewline; send_action(it);
    it = blank_item(ACT_CHAR); it.char_code = CharReturn; send_action(it);
    it = blank_item(ACT_CHAR_2X); it.char_code = CharReturn; send_action(it);
    it = blank_item(ACT_SET_CURSOR); it.x_position = 8'd255; it.y_position = 8'd255;
    send_action(it);
    it = blank_item(ACT_CHAR_2X); it.char_code = 8'h7F; it.glyph_columns = '1;
    send_action(it);
    it = blank_item(ACT_PIXEL); it.x_position = 8'd127; it.y_position = 8'd63;
    it.pixel_color = 1'b1; send_action(it);
    it = blank_item(ACT_PIXEL); it.x_position = 8'd128; it.y_position = 8'd0;
    it.pixel_color = 1'b1; send_action(it);
    it = blank_item(ACT_PIXEL); it.x_position = 8'd0; it.y_position = 8'd64; send_action(it);
    it = blank_item(ACT_PIXEL); it.x_position = 8'd127; it.y_position = 8'd63; send_action(it);
    it = blank_item(ACT_READ); it.read_address = 10'd1023; send_action(it);
    it = blank_item(ACT_READ); it.read_address = 10'd0; send_action(it);
    it = blank_item(ACT_CLEAR_LINE); it.page_index = 8'd7; send_action(it);
    it = blank_item(ACT_CLEAR_LINE); it.page_index = 8'd8; send_action(it);
    it = blank_item(ACT_CLEAR_LINE); it.page_index = 8'd255; send_action(it);
    it = blank_item(ACT_NONE); it = ~it; it.action = ACT_NONE; send_action(it);
    it = blank_item(ACT_CLEAR); send_action(it);
    drain_results();
  endtask

  // Mostly text runs at random cursors with reads and pixels mixed in, so that
  // wraps and clipping are reached often; clear is kept rare since it is slow.
  task automatic test_random();
    in_item_t it;
    for (int n = 0; n < 700; n++) begin
      it = random_item();
      if (action_t'(it.action) == ACT_CLEAR && $urandom_range(0, 9) != 0) it.action = ACT_READ;
      if (n % 40 == 0) begin
        it.action = ACT_SET_CURSOR;
      end else if ($urandom_range(0, 2) == 0) begin
        it.action = $urandom_range(0, 1) ? ACT_CHAR : ACT_CHAR_2X;
      end
      send_action(it);
    end
    drain_results();
  endtask

  // The receiver holds off for a long stretch while back-to-back transactions
  // are offered, so the output register fills and the input is stalled.
  task automatic test_backpressure();
    in_item_t it;
    long_hold = 1'b1;
    for (int n = 0; n < 30; n++) begin
      it = random_item();
      if (action_t'(it.action) == ACT_CLEAR) it.action = ACT_READ;
      send_action(it, 1'b1);
    end
    drain_results();
  endtask

  // Receiver side: random stall per result, one long hold on request, and
  // stretches where it never stalls.
  initial begin
    int hold;
    out_stall <= 1'b1;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      hold = recv_quiet ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) recv_quiet = ~recv_quiet;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          errors++;
        end
        if (out_data.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   out_data.read_data);
          errors++;
        end
        if (out_data.cursor_x_now !== want.cursor_x_now) begin
          $display("%0t: column of cursor expected %0d actual %0d", $time,
                   want.cursor_x_now, out_data.cursor_x_now);
          errors++;
        end
        if (out_data.cursor_y_now !== want.cursor_y_now) begin
          $display("%0t: row of cursor expected %0d actual %0d", $time,
                   want.cursor_y_now, out_data.cursor_y_now);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (pixel_bytes[i]) pixel_bytes[i] = 8'd0;
    cur_x = 8'd0;
    cur_y = 8'd0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Slowest run: ~760 transactions with their random gaps and stalls, a few
  // clears, and the clearing pass; far below this.
  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/pfb_pkg.sv
rtl/pfb_ctrl.sv
rtl/pfb_datapath.sv
rtl/page_framebuffer_text_blitter.sv
tb/tb_top.sv
